>>> hw/rtl/eilc_pkg.sv
// eilc_pkg: shared types and constants for the edge interrupt line controller.
// Register offsets, item kinds, and the item/result structs.
// No dependencies.
`default_nettype none

package eilc_pkg;

  localparam int unsigned LineCountDef = 20;
  localparam int unsigned PinCountDef  = 16;

  localparam int unsigned KindW   = 2;
  localparam int unsigned OffsetW = 10;
  localparam int unsigned DataW   = 32;
  localparam int unsigned PinW    = 4;
  localparam int unsigned IrqW    = 10;

  // item kinds
  localparam logic [KindW-1:0] KindRead  = 2'd0;
  localparam logic [KindW-1:0] KindWrite = 2'd1;
  localparam logic [KindW-1:0] KindPin   = 2'd2;

  // register byte offsets
  localparam logic [OffsetW-1:0] OfsMask  = 10'h000;
  localparam logic [OffsetW-1:0] OfsEvent = 10'h004;
  localparam logic [OffsetW-1:0] OfsRise  = 10'h008;
  localparam logic [OffsetW-1:0] OfsFall  = 10'h00c;
  localparam logic [OffsetW-1:0] OfsSoft  = 10'h010;
  localparam logic [OffsetW-1:0] OfsPend  = 10'h014;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [OffsetW-1:0] reg_offset;
    logic [DataW-1:0]   write_data;
    logic [PinW-1:0]    pin_line;
    logic               pin_level;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic [IrqW-1:0]  irq_lines;
    logic             bad_offset;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/eilc_core.sv
// eilc_core: per-line mask/select/trigger/pending registers and the
// combinational update and readback logic for one item.
// Depends on eilc_pkg.
`default_nettype none

module eilc_core import eilc_pkg::*; #(
  parameter int unsigned LINE_COUNT = LineCountDef,
  parameter int unsigned PIN_COUNT  = PinCountDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,   // apply item this cycle
  input  wire item_t   item_i,
  output      result_t result_o
);

  logic [LINE_COUNT-1:0] mask_q, mask_d;
  logic [LINE_COUNT-1:0] rise_q, rise_d;
  logic [LINE_COUNT-1:0] fall_q, fall_d;
  logic [LINE_COUNT-1:0] soft_q, soft_d;
  logic [LINE_COUNT-1:0] pend_q, pend_d;

  logic [LINE_COUNT-1:0] wr_val;
  logic [LINE_COUNT-1:0] hit;
  logic [LINE_COUNT-1:0] fresh;
  logic [LINE_COUNT-1:0] pin_sel;
  logic [LINE_COUNT-1:0] pin_bit;
  logic [LINE_COUNT-1:0] rd_val;
  logic                  bad;

  assign wr_val = item_i.write_data[LINE_COUNT-1:0];

  // one-hot pin decode; pins at or above PIN_COUNT select nothing
  always_comb begin
    for (int i = 0; i < LINE_COUNT; i++) begin
      pin_bit[i] = (i < PIN_COUNT) && (item_i.pin_line == PinW'(i));
    end
  end

  assign pin_sel = item_i.pin_level ? rise_q : fall_q;

  always_comb begin
    mask_d = mask_q;
    rise_d = rise_q;
    fall_d = fall_q;
    soft_d = soft_q;
    pend_d = pend_q;
    rd_val = '0;
    bad    = 1'b0;
    hit    = '0;
    fresh  = '0;
    case (item_i.kind)
      KindRead: begin
        unique case (item_i.reg_offset)
          OfsMask:  rd_val = mask_q;
          OfsEvent: rd_val = '0;
          OfsRise:  rd_val = rise_q;
          OfsFall:  rd_val = fall_q;
          OfsSoft:  rd_val = soft_q;
          OfsPend:  rd_val = pend_q;
          default:  bad = 1'b1;
        endcase
      end
      KindWrite: begin
        unique case (item_i.reg_offset)
          OfsMask:  mask_d = wr_val;
          OfsEvent: ;
          OfsRise: begin
            hit    = (wr_val ^ rise_q) & pend_q;
            pend_d = pend_q & ~hit;
            soft_d = soft_q & ~hit;
            rise_d = wr_val;
          end
          OfsFall: begin
            hit    = (wr_val ^ fall_q) & pend_q;
            pend_d = pend_q & ~hit;
            soft_d = soft_q & ~hit;
            fall_d = wr_val;
          end
          OfsSoft: begin
            // only 0 -> 1 transitions trigger
            fresh  = wr_val & ~soft_q;
            soft_d = soft_q | fresh;
            pend_d = pend_q | (fresh & mask_q);
          end
          OfsPend: begin
            hit    = wr_val & pend_q;
            pend_d = pend_q & ~hit;
            soft_d = soft_q & ~hit;
          end
          default: bad = 1'b1;
        endcase
      end
      KindPin: begin
        pend_d = pend_q | (pin_sel & mask_q & pin_bit);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      rise_q <= '0;
      fall_q <= '0;
      soft_q <= '0;
      pend_q <= '0;
    end else if (step_i) begin
      mask_q <= mask_d;
      rise_q <= rise_d;
      fall_q <= fall_d;
      soft_q <= soft_d;
      pend_q <= pend_d;
    end
  end

  // IRQ grouping: 0-4 direct, 5-9 and 10-15 ORed, 16-18 direct
  assign result_o.irq_lines = {pend_d[18:16], |pend_d[15:10], |pend_d[9:5], pend_d[4:0]};
  assign result_o.read_data = DataW'(rd_val);
  assign result_o.bad_offset = bad;

endmodule

`default_nettype wire

>>> hw/rtl/edge_interrupt_line_controller.sv
// edge_interrupt_line_controller: top level with input and result registers
// around eilc_core. Depends on eilc_pkg and eilc_core.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item per transfer: a
//   bus read, a bus write, or a pin level change (kind_i selects). Output
//   channel (out_valid_o/out_ready_i) returns exactly one result per item:
//   read_data_o, irq_lines_o (the ten interrupt levels after the item) and
//   bad_offset_o.
//   Pipeline: an item is taken into the input register, then applied to the
//   line registers as its result is loaded into the result register (two
//   register stages: the input register, then the result register).
//   Throughput: one item per cycle while out_ready_i is high. The update is
//   a bitwise pass over the 20-bit line registers, so the state written by
//   one item is ready for the next item in the following cycle.
//   Stall: when the receiver holds out_ready_i low, the result register holds
//   its transfer, one more item waits in the input register, and in_ready_o
//   drops until the result is taken.
//   Reset (rst_ni low, asynchronous): all line registers clear to zero, both
//   stages empty; no result is pending.
//   Undefined offsets read zero, change nothing and flag bad_offset_o.
`default_nettype none

module edge_interrupt_line_controller import eilc_pkg::*; #(
  parameter int unsigned LINE_COUNT = LineCountDef,
  parameter int unsigned PIN_COUNT  = PinCountDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [KindW-1:0]   kind_i,
  input  wire logic [OffsetW-1:0] reg_offset_i,
  input  wire logic [DataW-1:0]   write_data_i,
  input  wire logic [PinW-1:0]    pin_line_i,
  input  wire logic               pin_level_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [DataW-1:0]   read_data_o,
  output      logic [IrqW-1:0]    irq_lines_o,
  output      logic               bad_offset_o
);

  item_t   in_q;
  logic    in_valid_q;
  result_t out_q;
  logic    out_valid_q;
  result_t core_res;
  logic    advance;
  logic    in_take;

  // item moves from input register to result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= '{kind: kind_i, reg_offset: reg_offset_i, write_data: write_data_i,
                pin_line: pin_line_i, pin_level: pin_level_i};
    end
  end

  eilc_core #(
    .LINE_COUNT(LINE_COUNT),
    .PIN_COUNT (PIN_COUNT)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_q),
    .result_o(core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_q.read_data;
  assign irq_lines_o  = out_q.irq_lines;
  assign bad_offset_o = out_q.bad_offset;

endmodule

`default_nettype wire

>>> hw/rtl/eilc_checker.sv
// eilc_checker: port-level assertions for edge_interrupt_line_controller,
// bound to the top level. Depends on eilc_pkg.
`default_nettype none

module eilc_checker import eilc_pkg::*; #(
  parameter int unsigned LINE_COUNT = LineCountDef
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [DataW-1:0]   read_data_o,
  input wire logic [IrqW-1:0]    irq_lines_o,
  input wire logic               bad_offset_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(irq_lines_o) && $stable(bad_offset_o))
    else $error("result changed while stalled");

  // a bad offset never returns data
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_offset_o |-> read_data_o == '0)
    else $error("bad offset with nonzero read data");

  // bits above the line count always read zero
  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_data_o >> LINE_COUNT) == '0)
    else $error("read data above line count nonzero");

  // an accepted item with an empty output yields a result once it passes the input and result registers
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("accepted item produced no result");

endmodule

bind edge_interrupt_line_controller eilc_checker #(
  .LINE_COUNT(LINE_COUNT)
) u_eilc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .read_data_o (read_data_o),
  .irq_lines_o (irq_lines_o),
  .bad_offset_o(bad_offset_o)
);

`default_nettype wire
